[src/dqz_pkg.sv]
// Shared constants, tables and types of the 8x8 DCT quantizer.
package dqz_pkg;

  localparam int COS_FRAC_BITS = 14;
  localparam int ROW_FRAC_BITS = 7;
  localparam int COS_SHIFT     = 16 - COS_FRAC_BITS;
  localparam int ROW_SHIFT     = COS_FRAC_BITS - ROW_FRAC_BITS;
  localparam int PIX_W         = 8;
  localparam int SMP_W         = 9;
  localparam int ROW_W         = 18;
  localparam int WGT_W         = COS_FRAC_BITS + 1;
  localparam int PROD_W        = ROW_W + WGT_W;
  localparam int ACC_W         = PROD_W + 3;
  localparam int Q_W           = 7;
  localparam int QUO_W         = 10;
  localparam int CNT_W         = $clog2(QUO_W);
  localparam int DEN_SHIFT     = ROW_FRAC_BITS + COS_FRAC_BITS;
  localparam int DIV_W         = DEN_SHIFT + Q_W + QUO_W;
  localparam int COEF_W        = 9;

  typedef struct packed {
    logic       v;
    logic       first;
    logic       last;
    logic [5:0] tag;
  } mac_ctl_t;

  localparam logic [15:0] COS_MAG16 [0:8] = '{
    16'd32768, 16'd32138, 16'd30274, 16'd27246, 16'd23170,
    16'd18205, 16'd12540, 16'd6393, 16'd0
  };

  localparam logic [6:0] Q50 [0:63] = '{
    7'd16, 7'd11, 7'd10, 7'd16, 7'd24, 7'd40, 7'd51, 7'd61,
    7'd12, 7'd12, 7'd14, 7'd19, 7'd26, 7'd58, 7'd60, 7'd55,
    7'd14, 7'd13, 7'd16, 7'd24, 7'd40, 7'd57, 7'd69, 7'd56,
    7'd14, 7'd17, 7'd22, 7'd29, 7'd51, 7'd87, 7'd80, 7'd62,
    7'd18, 7'd22, 7'd37, 7'd56, 7'd68, 7'd109, 7'd103, 7'd77,
    7'd24, 7'd35, 7'd55, 7'd64, 7'd81, 7'd104, 7'd113, 7'd92,
    7'd49, 7'd64, 7'd78, 7'd87, 7'd103, 7'd121, 7'd120, 7'd101,
    7'd72, 7'd92, 7'd95, 7'd98, 7'd112, 7'd100, 7'd103, 7'd99
  };

  // zigzag position -> {row i, column j}
  localparam logic [5:0] ZZ_IJ [0:63] = '{
    6'o00, 6'o01, 6'o10, 6'o20, 6'o11, 6'o02, 6'o03, 6'o12,
    6'o21, 6'o30, 6'o40, 6'o31, 6'o22, 6'o13, 6'o04, 6'o05,
    6'o14, 6'o23, 6'o32, 6'o41, 6'o50, 6'o60, 6'o51, 6'o42,
    6'o33, 6'o24, 6'o15, 6'o06, 6'o07, 6'o16, 6'o25, 6'o34,
    6'o43, 6'o52, 6'o61, 6'o70, 6'o71, 6'o62, 6'o53, 6'o44,
    6'o35, 6'o26, 6'o17, 6'o27, 6'o36, 6'o45, 6'o54, 6'o63,
    6'o72, 6'o73, 6'o64, 6'o55, 6'o46, 6'o37, 6'o47, 6'o56,
    6'o65, 6'o74, 6'o75, 6'o66, 6'o57, 6'o67, 6'o76, 6'o77
  };

  // 0.5*c(u)*cos((2x+1)u pi/16) with COS_FRAC_BITS fraction bits
  function automatic logic signed [WGT_W-1:0] cos_weight(input logic [2:0] u,
                                                         input logic [2:0] x);
    logic [7:0]       p;
    logic [4:0]       m;
    logic [16:0]      mag;
    logic [16:0]      rnd;
    logic             neg;
    logic [WGT_W-1:0] w;
    p   = {4'b0, x, 1'b1} * {5'b0, u};
    m   = p[4:0];
    neg = 1'b0;
    if (u == 3'd0) begin
      mag = 17'd23170;
    end else begin
      if (m > 5'd16) m = 5'd0 - m;
      if (m > 5'd8) begin
        mag = {1'b0, COS_MAG16[4'(5'd16 - m)]};
        neg = 1'b1;
      end else begin
        mag = {1'b0, COS_MAG16[4'(m)]};
      end
    end
    if (COS_SHIFT == 0) rnd = mag;
    else rnd = (mag + (17'd1 << (COS_SHIFT - 1))) >> COS_SHIFT;
    w = rnd[WGT_W-1:0];
    if (neg) w = -w;
    return $signed(w);
  endfunction

endpackage

[src/dqz_mac.sv]
// Shared multiply-accumulate unit: registered product, then accumulator.
module dqz_mac import dqz_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_ctl_t                ctl,
  input  logic signed [ROW_W-1:0] a,
  input  logic signed [WGT_W-1:0] b,
  output logic                    done,
  output logic [5:0]              done_tag,
  output logic signed [ACC_W-1:0] acc
);

  mac_ctl_t                 ctl1;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_x;

  assign prod_x = ACC_W'(prod);

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (rst) ctl1 <= '0;
    else ctl1 <= ctl;
    if (ctl1.v) begin
      acc <= ctl1.first ? prod_x : acc + prod_x;
    end
    done_tag <= ctl1.tag;
    if (rst) done <= 1'b0;
    else done <= ctl1.v & ctl1.last;
  end

endmodule

[src/dqz_div.sv]
// Restoring divider, one quotient bit per cycle, for quantization.
module dqz_div import dqz_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [Q_W-1:0]   qv,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (start) begin
      rem <= dividend;
      dsr <= DIV_W'(qv) << (DEN_SHIFT + QUO_W - 1);
      cnt <= CNT_W'(QUO_W - 1);
      quo <= '0;
    end else if (busy) begin
      if (rem >= dsr) begin
        rem <= rem - dsr;
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
      dsr <= dsr >> 1;
      cnt <= cnt - 1'b1;
    end
  end

endmodule

[src/dct8x8_quantize_zigzag.sv]
// Top level: 8x8 forward DCT, Q50 quantizer and zigzag reorder.
//
// Input channel (in_valid, in_stall, pixel): 64 samples of one block in
// row-major order, one request per sample. in_stall is low only while the
// block is collecting samples.
// Output channel (out_valid, out_stall, coefficient, zigzag_position, last):
// 64 quantized coefficients in zigzag order; last marks position 63.
// When the receiver holds out_stall high, the current coefficient and its
// position stay on the ports and all computation waits.
// After the 64th sample: a row pass of 512 products through the shared MAC,
// then per coefficient 8 products through the MAC pipeline, a bit-serial
// quantize division and the output step. The single multiplier and the
// bit-serial quantize divider limit the throughput; samples of a new block
// are taken only after the last coefficient of the current block has left.
// Register 0 (APB byte address 0): bit 0 enables the level shift of -128.
// Reset (rst, synchronous): block starts empty, level shift off. The sample
// and row stores are not cleared; each entry is written before it is read.
module dct8x8_quantize_zigzag import dqz_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [PIX_W-1:0]         pixel,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [COEF_W-1:0] coefficient,
  output logic [5:0]               zigzag_position,
  output logic                     last
);

  localparam logic [2:0] REG_LEVEL_SHIFT = 3'd0;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_ROW   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_CMAC  = 3'd3;
  localparam logic [2:0] S_CWAIT = 3'd4;
  localparam logic [2:0] S_CDIV  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state;
  logic [5:0] loaded;
  logic [8:0] term;      // row pass {y, j, x}
  logic [5:0] k;         // zigzag position in column pass
  logic [2:0] ycnt;
  logic       lse;
  logic       neg;

  logic [PIX_W-1:0] sample_store [0:63];
  logic [ROW_W-1:0] row_store [0:63];

  // APB register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) lse <= 1'b0;
    else if (psel && penable && pwrite && pready && paddr == REG_LEVEL_SHIFT) lse <= pwdata[0];
  end
  assign prdata = (paddr == REG_LEVEL_SHIFT) ? {31'b0, lse} : 32'b0;

  assign in_stall  = (state != S_LOAD);
  assign out_valid = (state == S_OUT);

  // issue side of the MAC pipeline
  logic [5:0]              ij;
  logic [5:0]              smp_addr;
  logic [5:0]              row_addr;
  logic signed [WGT_W-1:0] wgt;
  mac_ctl_t                ctl_iss;

  assign ij       = ZZ_IJ[k];
  assign smp_addr = {term[8:6], term[2:0]};
  assign row_addr = {ycnt, ij[2:0]};

  always_comb begin
    ctl_iss = '0;
    wgt     = cos_weight(ij[5:3], ycnt);
    if (state == S_ROW) begin
      wgt           = cos_weight(term[5:3], term[2:0]);
      ctl_iss.v     = 1'b1;
      ctl_iss.first = (term[2:0] == 3'd0);
      ctl_iss.last  = (term[2:0] == 3'd7);
      ctl_iss.tag   = {term[8:6], term[5:3]};
    end else if (state == S_CMAC) begin
      ctl_iss.v     = 1'b1;
      ctl_iss.first = (ycnt == 3'd0);
      ctl_iss.last  = (ycnt == 3'd7);
      ctl_iss.tag   = k;
    end
  end

  // memory read stage
  logic [PIX_W-1:0]        smp_rd;
  logic [ROW_W-1:0]        row_rd;
  mac_ctl_t                ctl0;
  logic signed [WGT_W-1:0] w0;
  logic                    col0;

  always_ff @(posedge clk) begin
    smp_rd <= sample_store[smp_addr];
    row_rd <= row_store[row_addr];
    w0     <= wgt;
    col0   <= (state == S_CMAC);
    if (rst) ctl0 <= '0;
    else ctl0 <= ctl_iss;
  end

  logic [SMP_W-1:0]        smp_s;
  logic signed [ROW_W-1:0] mac_a;

  assign smp_s = {1'b0, smp_rd} - (lse ? SMP_W'(128) : SMP_W'(0));
  assign mac_a = col0 ? $signed(row_rd) : $signed({{(ROW_W-SMP_W){smp_s[SMP_W-1]}}, smp_s});

  logic                    mac_done;
  logic [5:0]              mac_tag;
  logic signed [ACC_W-1:0] mac_acc;

  dqz_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl0),
    .a        (mac_a),
    .b        (w0),
    .done     (mac_done),
    .done_tag (mac_tag),
    .acc      (mac_acc)
  );

  // magnitude of the accumulator, for both rounding and quantizing
  logic [ACC_W-1:0] acc_mag;
  logic [ACC_W-1:0] row_mag;
  logic [ROW_W-1:0] row_val;

  assign acc_mag = mac_acc[ACC_W-1] ? ACC_W'(-mac_acc) : ACC_W'(mac_acc);
  assign row_mag = (acc_mag + (ACC_W'(1) << (ROW_SHIFT - 1))) >> ROW_SHIFT;
  assign row_val = mac_acc[ACC_W-1] ? ROW_W'(-row_mag) : row_mag[ROW_W-1:0];

  always_ff @(posedge clk) begin
    if (state == S_LOAD && in_valid) sample_store[loaded] <= pixel;
    if (mac_done && (state == S_ROW || state == S_DRAIN)) row_store[mac_tag] <= row_val;
  end

  // quantize: (|D| + den/2) / den, den = Q50 << DEN_SHIFT
  logic [Q_W-1:0]   qv;
  logic [DIV_W-1:0] dividend;
  logic             div_start;
  logic             div_done;
  logic [QUO_W-1:0] quo;

  assign qv        = Q50[ij];
  assign dividend  = DIV_W'(acc_mag) + (DIV_W'(qv) << (DEN_SHIFT - 1));
  assign div_start = (state == S_CWAIT) && mac_done;

  dqz_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .qv       (qv),
    .done     (div_done),
    .quo      (quo)
  );

  logic [COEF_W-1:0] coef_next;
  always_comb begin
    if (neg) begin
      coef_next = (quo > QUO_W'(256)) ? COEF_W'(256) : COEF_W'(quo);
      coef_next = -coef_next;
    end else begin
      coef_next = (quo > QUO_W'(255)) ? COEF_W'(255) : COEF_W'(quo);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_LOAD;
      loaded <= '0;
      term   <= '0;
      k      <= '0;
      ycnt   <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_valid) begin
            loaded <= loaded + 1'b1;
            if (loaded == 6'd63) begin
              state <= S_ROW;
              term  <= '0;
            end
          end
        end
        S_ROW: begin
          term <= term + 1'b1;
          if (term == 9'd511) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (mac_done && mac_tag == 6'd63) begin
            state <= S_CMAC;
            k     <= '0;
            ycnt  <= '0;
          end
        end
        S_CMAC: begin
          ycnt <= ycnt + 1'b1;
          if (ycnt == 3'd7) state <= S_CWAIT;
        end
        S_CWAIT: begin
          if (mac_done) state <= S_CDIV;
        end
        S_CDIV: begin
          if (div_done) state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            if (k == 6'd63) begin
              state <= S_LOAD;
            end else begin
              k     <= k + 1'b1;
              ycnt  <= '0;
              state <= S_CMAC;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) neg <= mac_acc[ACC_W-1];
    if (state == S_CDIV && div_done) begin
      coefficient     <= $signed(coef_next);
      zigzag_position <= k;
      last            <= (k == 6'd63);
    end
  end

  // never take samples while a coefficient is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid) else $error("input taken while output valid");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> zigzag_position == 6'd63) else $error("last flag misplaced");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_CDIV) else $error("divider result outside quantize step");

  a_mac_col: assert property (@(posedge clk) disable iff (rst)
    (state == S_CWAIT && mac_done) |-> mac_tag == k) else $error("column sum tag mismatch");

endmodule
